[src/kcw_pkg.sv]
`timescale 1ns / 1ps
package kcw_pkg;

  // opcodes of the input word
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_RECORD = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_EXPIRY  = 2'd0;
  localparam logic [1:0] CFG_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_MAX_ERA = 2'd2;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] EXPIRY_RST  = 16'd600;
  localparam logic [9:0]  PERIOD_RST  = 10'd30;
  localparam logic [6:0]  MAX_ERA_RST = 7'd4;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic        step;
    logic [31:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic [31:0] cost_us;
    logic        from_fallback;
    logic        status;
    logic [6:0]  erased_count;
  } out_t;

endpackage

[src/keyed_cost_window_table.sv]
`timescale 1ns / 1ps
// Keyed cost window table. Accepts one command word when start is high and busy is low;
// each command gives exactly one result word, shown for one cycle with out_valid high,
// and the receiver cannot stall it. Slot keys and per-slot statistics share one
// synchronous memory and the sample rings sit in a second, walked one slot at a time
// (read, then evaluate). A key lookup walks up to TABLE_ENTRIES slots; a record adds a
// read-modify-write; a query hit adds a slot read and one serial divide of DW quotient
// bits (DW = max(32+log2(WINDOW_SIZE), 32+log2(TABLE_ENTRIES))); a fallback query
// walks every slot and runs one serial divide per slot that holds samples plus, if any
// did, one final divide. A frame tick runs one divide for the cleanup period test and,
// on a cleanup tick, a scan of up to TABLE_ENTRIES slots. All divides share one radix-2
// divider. No clearing pass is needed after reset.
module keyed_cost_window_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int WINDOW_SIZE   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kcw_pkg::in_t       in_data,
  output logic               out_valid,
  output kcw_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [kcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kcw_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int WIN_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = 32 + $clog2(WINDOW_SIZE);
  localparam int WIN_AW = $clog2(TABLE_ENTRIES * WINDOW_SIZE);
  localparam int ACC_W  = 32 + IDX_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam int DW     = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int VW     = (CNT_W > 10) ? CNT_W : 10;
  localparam int DC_W   = $clog2(DW);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_SIZE);
  localparam logic [WIN_W-1:0]  NEXT_MAX = WIN_W'(WINDOW_SIZE - 1);

  // controller states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_LK_RD  = 4'd2;
  localparam logic [3:0] S_LK_EV  = 4'd3;
  localparam logic [3:0] S_REC_RD = 4'd4;
  localparam logic [3:0] S_REC_EV = 4'd5;
  localparam logic [3:0] S_REC_WR = 4'd6;
  localparam logic [3:0] S_FB_RD  = 4'd7;
  localparam logic [3:0] S_FB_EV  = 4'd8;
  localparam logic [3:0] S_CL_RD  = 4'd9;
  localparam logic [3:0] S_CL_EV  = 4'd10;

  // what to do with a finished divide
  localparam logic [1:0] RET_TICK = 2'd0;
  localparam logic [1:0] RET_Q    = 2'd1;
  localparam logic [1:0] RET_FB   = 2'd2;
  localparam logic [1:0] RET_FBF  = 2'd3;

  // per-slot key and statistics word
  typedef struct packed {
    logic [63:0]       key;
    logic [31:0]       partial;
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] fill;
    logic [WIN_W-1:0]  next;
    logic              ever;
    logic [31:0]       last;
  } info_t;

  // memories
  info_t       info_mem [TABLE_ENTRIES];
  logic [31:0] win_mem  [TABLE_ENTRIES * WINDOW_SIZE];

  // configuration
  logic [15:0] expiry_r;
  logic [9:0]  period_r;
  logic [6:0]  max_erase_r;

  // control state
  logic [3:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  in_t                item_r, item_nxt;
  logic [31:0]        fc_r, fc_nxt;
  logic [6:0]         erased_r, erased_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  // serial divider
  logic [VW-1:0]   div_rem_r, div_rem_nxt;
  logic [DW-1:0]   div_q_r, div_q_nxt;
  logic [VW-1:0]   div_d_r, div_d_nxt;
  logic [DC_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [1:0]      ret_r, ret_nxt;
  logic [VW:0]     div_tmp;
  logic            div_ge;
  logic [VW-1:0]   div_rem_step;
  logic [DW-1:0]   div_q_step;

  // memory ports
  info_t             info_q_r;
  logic [31:0]       win_q_r;
  logic [IDX_W-1:0]  info_raddr;
  logic [WIN_AW-1:0] win_addr;
  logic              info_we;
  logic [IDX_W-1:0]  info_waddr;
  info_t             info_wdata;
  logic              win_we;
  logic [31:0]       win_wdata;

  // record datapath
  logic [32:0]       rec_total;
  logic [31:0]       rec_val;
  logic [31:0]       rec_old;
  logic              rec_not_full;

  // cleanup datapath
  logic [31:0]       age;
  logic              expired;

  // sequencing helpers
  logic              div_go;
  logic [DW-1:0]     div_a;
  logic [VW-1:0]     div_b;
  logic [1:0]        div_ret;
  logic              fb_go;
  logic              fb_adv;
  logic              fin;
  logic [31:0]       fin_cost;
  logic              fin_fb;
  logic              fin_status;
  logic [6:0]        fin_erased;
  logic              free_now;
  logic [IDX_W-1:0]  free_sel;
  logic [6:0]        erased_inc;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r    <= EXPIRY_RST;
      period_r    <= PERIOD_RST;
      max_erase_r <= MAX_ERA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPIRY:  expiry_r    <= cfg_data;
        CFG_PERIOD:  period_r    <= cfg_data[9:0];
        CFG_MAX_ERA: max_erase_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // memory addressing: scans read at the walk index, records at the chosen slot
  assign info_raddr = (state_r == S_LK_RD || state_r == S_FB_RD || state_r == S_CL_RD) ?
                      idx_r : slot_r;
  assign win_addr   = WIN_AW'(slot_r) * WIN_AW'(WINDOW_SIZE) + WIN_AW'(info_q_r.next);

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_q_r <= info_mem[info_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_addr] <= win_wdata;
    end
    win_q_r <= win_mem[win_addr];
  end

  // divider step, one quotient bit per cycle
  always_comb begin
    div_tmp      = {div_rem_r, div_q_r[DW-1]};
    div_ge       = (div_tmp >= {1'b0, div_d_r});
    div_rem_step = div_ge ? VW'(div_tmp - {1'b0, div_d_r}) : div_tmp[VW-1:0];
    div_q_step   = {div_q_r[DW-2:0], div_ge};
  end

  // final sample: saturated total; the old ring sample is subtracted only once the ring is full
  always_comb begin
    rec_total    = {1'b0, item_r.elapsed_us} + {1'b0, info_q_r.partial};
    rec_val      = rec_total[32] ? SAT32 : rec_total[31:0];
    rec_not_full = (info_q_r.fill < FILL_MAX);
    rec_old      = rec_not_full ? 32'd0 : win_q_r;
  end

  // expiry test for cleanup
  assign age     = fc_r - info_q_r.last;
  assign expired = !info_q_r.ever || (age >= {16'd0, expiry_r});

  assign free_now   = free_found_r || !valid_r[idx_r];
  assign free_sel   = free_found_r ? free_idx_r : idx_r;
  assign erased_inc = erased_r + 7'd1;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    item_nxt       = item_r;
    fc_nxt         = fc_r;
    erased_nxt     = erased_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    div_rem_nxt    = div_rem_r;
    div_q_nxt      = div_q_r;
    div_d_nxt      = div_d_r;
    div_cnt_nxt    = div_cnt_r;
    ret_nxt        = ret_r;
    info_we        = 1'b0;
    info_waddr     = slot_r;
    info_wdata     = info_q_r;
    win_we         = 1'b0;
    win_wdata      = rec_val;
    div_go         = 1'b0;
    div_a          = '0;
    div_b          = '0;
    div_ret        = RET_TICK;
    fb_go          = 1'b0;
    fb_adv         = 1'b0;
    fin            = 1'b0;
    fin_cost       = 32'd0;
    fin_fb         = 1'b0;
    fin_status     = 1'b0;
    fin_erased     = 7'd0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt       = in_data;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          case (in_data.op)
            OP_TICK: begin
              // cleanup when the new frame count is a multiple of the period
              fc_nxt  = fc_r + 32'd1;
              div_go  = 1'b1;
              div_a   = DW'(fc_nxt);
              div_b   = (period_r == 10'd0) ? VW'(1) : VW'(period_r);
              div_ret = RET_TICK;
            end
            OP_RECORD, OP_QUERY: begin
              state_nxt = S_LK_RD;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_LK_RD: begin
        state_nxt = S_LK_EV;
      end

      S_LK_EV: begin
        if (valid_r[idx_r] && info_q_r.key == item_r.key) begin
          slot_nxt  = idx_r;
          state_nxt = S_REC_RD;
        end else if (idx_r == LAST_IDX) begin
          if (item_r.op == OP_QUERY) begin
            fb_go = 1'b1;
          end else if (free_now) begin
            // allocate the lowest free slot with cleared statistics
            slot_nxt            = free_sel;
            valid_nxt[free_sel] = 1'b1;
            info_we             = 1'b1;
            info_waddr          = free_sel;
            info_wdata          = '0;
            info_wdata.key      = item_r.key;
            state_nxt           = S_REC_RD;
          end else begin
            fin        = 1'b1;
            fin_status = 1'b1;
          end
        end else begin
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_LK_RD;
        end
      end

      S_REC_RD: begin
        state_nxt = S_REC_EV;
      end

      S_REC_EV: begin
        if (item_r.op == OP_QUERY) begin
          if (info_q_r.fill != '0) begin
            div_go  = 1'b1;
            div_a   = DW'(info_q_r.sum);
            div_b   = VW'(info_q_r.fill);
            div_ret = RET_Q;
          end else begin
            fb_go = 1'b1;
          end
        end else if (!item_r.step) begin
          info_we            = 1'b1;
          info_wdata.partial = item_r.elapsed_us;
          fin                = 1'b1;
        end else begin
          // ring word read is under way at win_addr
          state_nxt = S_REC_WR;
        end
      end

      S_REC_WR: begin
        win_we          = 1'b1;
        info_we         = 1'b1;
        info_wdata.sum  = info_q_r.sum - SUM_W'(rec_old) + SUM_W'(rec_val);
        info_wdata.fill = rec_not_full ? info_q_r.fill + FILL_W'(1) : info_q_r.fill;
        info_wdata.next = (info_q_r.next == NEXT_MAX) ? '0 : info_q_r.next + WIN_W'(1);
        info_wdata.ever = 1'b1;
        info_wdata.last = fc_r;
        fin             = 1'b1;
      end

      S_FB_RD: begin
        state_nxt = S_FB_EV;
      end

      S_FB_EV: begin
        if (valid_r[idx_r] && info_q_r.fill != '0) begin
          div_go  = 1'b1;
          div_a   = DW'(info_q_r.sum);
          div_b   = VW'(info_q_r.fill);
          div_ret = RET_FB;
        end else begin
          fb_adv = 1'b1;
        end
      end

      S_CL_RD: begin
        state_nxt = S_CL_EV;
      end

      S_CL_EV: begin
        if (valid_r[idx_r] && expired) begin
          valid_nxt[idx_r] = 1'b0;
          erased_nxt       = erased_inc;
        end
        if (erased_nxt == max_erase_r || idx_r == LAST_IDX) begin
          fin        = 1'b1;
          fin_erased = erased_nxt;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_CL_RD;
        end
      end

      S_DIV: begin
        div_rem_nxt = div_rem_step;
        div_q_nxt   = div_q_step;
        div_cnt_nxt = div_cnt_r + DC_W'(1);
        if (div_cnt_r == DC_W'(DW - 1)) begin
          case (ret_r)
            RET_TICK: begin
              if (div_rem_step != '0 || max_erase_r == 7'd0) begin
                fin = 1'b1;
              end else begin
                idx_nxt    = '0;
                erased_nxt = 7'd0;
                state_nxt  = S_CL_RD;
              end
            end
            RET_Q: begin
              fin      = 1'b1;
              fin_cost = div_q_step[31:0];
            end
            RET_FB: begin
              acc_nxt = acc_r + ACC_W'(div_q_step[31:0]);
              cnt_nxt = cnt_r + CNT_W'(1);
              fb_adv  = 1'b1;
            end
            RET_FBF: begin
              fin      = 1'b1;
              fin_fb   = 1'b1;
              fin_cost = div_q_step[31:0];
            end
            default: ;
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // fallback walk: next slot, or the final mean over slot averages
    if (fb_adv) begin
      if (idx_r == LAST_IDX) begin
        if (cnt_nxt == '0) begin
          fin    = 1'b1;
          fin_fb = 1'b1;
        end else begin
          div_go  = 1'b1;
          div_a   = DW'(acc_nxt);
          div_b   = VW'(cnt_nxt);
          div_ret = RET_FBF;
        end
      end else begin
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_FB_RD;
      end
    end

    if (fb_go) begin
      idx_nxt   = '0;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      state_nxt = S_FB_RD;
    end

    if (div_go) begin
      div_rem_nxt = '0;
      div_q_nxt   = div_a;
      div_d_nxt   = div_b;
      div_cnt_nxt = '0;
      ret_nxt     = div_ret;
      state_nxt   = S_DIV;
    end

    if (fin) begin
      out_valid_nxt         = 1'b1;
      out_nxt.cost_us       = fin_cost;
      out_nxt.from_fallback = fin_fb;
      out_nxt.status        = fin_status;
      out_nxt.erased_count  = fin_erased;
      state_nxt             = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= 32'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    item_r       <= item_nxt;
    erased_r     <= erased_nxt;
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    out_r        <= out_nxt;
    div_rem_r    <= div_rem_nxt;
    div_q_r      <= div_q_nxt;
    div_d_r      <= div_d_nxt;
    div_cnt_r    <= div_cnt_nxt;
    ret_r        <= ret_nxt;
  end

  // a result word only appears once the controller is back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // every accepted word either starts work or answers in the next cycle
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word dropped");

  // divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_d_r != '0))
    else $error("divide by zero");

  // cleanup never frees more than the limit
  a_erase_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.erased_count <= max_erase_r))
    else $error("erase limit exceeded");

endmodule
